// ===== design/chacha20_poly1305_aead_macros.svh =====
// Assertion macros shared by the design files.
`ifndef CHACHA20_POLY1305_AEAD_MACROS_SVH
`define CHACHA20_POLY1305_AEAD_MACROS_SVH

`ifndef SYNTHESIS
`define CPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPA_ASSERT_IMP(label, ante, cons, msg)
`define CPA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/cpa_pkg.sv =====
package cpa_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int GEN_STEPS     = 4 * DOUBLE_ROUNDS;
    localparam int GEN_CNT_W     = $clog2(GEN_STEPS);

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
    localparam logic [129:0] POLY_P  = {2'b11, {124{1'b1}}, 4'b1011};

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCEL = 3'd4;
    localparam logic [2:0] REG_NONCEH = 3'd5;
    localparam logic [2:0] REG_DIR    = 3'd6;

    typedef enum logic [1:0] {
        IK_AAD  = 2'd0,
        IK_TEXT = 2'd1,
        IK_TAG  = 2'd2,
        IK_FIN  = 2'd3
    } item_kind_t;

    typedef enum logic [1:0] {
        EM_TEXT = 2'd0,
        EM_TAG  = 2'd1,
        EM_STAT = 2'd2,
        EM_REJ  = 2'd3
    } emit_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AAD  = 2'd1,
        PH_TEXT = 2'd2,
        PH_TAG  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic        direction;
    } cpa_cfg_t;

    typedef struct packed {
        logic             accept;
        logic             start;
        logic             gen_load;
        logic             gen_step;
        logic             gen_half;
        logic             gen_diag;
        logic             gen_done;
        logic             gen_blk0;
        logic             mac_aad;
        logic             text_step;
        logic             tag_store;
        logic             mul_start;
        logic             mul_len;
        logic             mul_step;
        logic             mul_last;
        logic [3:0]       mul_digit;
        logic             fin_fold;
        logic             fin_sub;
        logic             fin_pad;
        logic             emit;
        emit_kind_t       emit_kind;
        logic [3:0]       emit_idx;
        logic             emit_last;
    } cpa_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic fill_15;
        logic pos_zero;
        logic tcnt_full;
        logic out_free;
    } cpa_stat_t;

    function automatic logic [127:0] qhalf(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d,
                                           input logic second);
        logic [31:0] a1;
        logic [31:0] b1;
        logic [31:0] c1;
        logic [31:0] d1;
        logic [31:0] dx;
        logic [31:0] bx;
        a1 = a + b;
        dx = d ^ a1;
        d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = c + d1;
        bx = b ^ c1;
        b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        return {a1, b1, c1, d1};
    endfunction

endpackage

// ===== design/cpa_ctrl.sv =====
`include "chacha20_poly1305_aead_macros.svh"

module cpa_ctrl
    import cpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    input  logic       direction,
    input  cpa_stat_t  stat,
    output logic       s_tready,
    output cpa_cmd_t   cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_GLOAD = 13'b0000000000100,
        S_GEN   = 13'b0000000001000,
        S_GEND  = 13'b0000000010000,
        S_DO    = 13'b0000000100000,
        S_TEXT  = 13'b0000001000000,
        S_TEXT2 = 13'b0000010000000,
        S_MUL   = 13'b0000100000000,
        S_FIN1  = 13'b0001000000000,
        S_FIN2  = 13'b0010000000000,
        S_FIN3  = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    state_t                 gen_ret_reg, gen_ret_next;
    state_t                 mul_ret_reg, mul_ret_next;
    phase_t                 phase_reg, phase_next;
    item_kind_t             kind_reg, kind_next;
    emit_kind_t             ek_reg, ek_next;
    logic [GEN_CNT_W-1:0]   gen_cnt_reg, gen_cnt_next;
    logic [3:0]             mul_cnt_reg, mul_cnt_next;
    logic [3:0]             idx_reg, idx_next;
    logic                   blk0_reg, blk0_next;
    logic                   ok;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (kind_reg)
            IK_AAD:  ok = (phase_reg == PH_IDLE) || (phase_reg == PH_AAD);
            IK_TEXT: ok = (phase_reg != PH_TAG);
            IK_TAG:  ok = direction && !stat.tcnt_full;
            IK_FIN:  ok = 1'b1;
            default: ok = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        gen_ret_next = gen_ret_reg;
        mul_ret_next = mul_ret_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        ek_next      = ek_reg;
        gen_cnt_next = gen_cnt_reg;
        mul_cnt_next = mul_cnt_reg;
        idx_next     = idx_reg;
        blk0_next    = blk0_reg;
        cmd          = '0;
        cmd.accept    = s_tvalid && (state_reg == S_IDLE);
        cmd.gen_half  = gen_cnt_reg[0];
        cmd.gen_diag  = gen_cnt_reg[1];
        cmd.gen_blk0  = blk0_reg;
        cmd.mul_digit = mul_cnt_reg;
        cmd.emit_kind = ek_reg;
        cmd.emit_idx  = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = item_kind_t'(s_tuser);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!ok)
                begin
                    ek_next    = EM_REJ;
                    state_next = S_EMIT;
                end
                else if (phase_reg == PH_IDLE)
                begin
                    cmd.start    = 1'b1;
                    blk0_next    = 1'b1;
                    gen_ret_next = S_DO;
                    phase_next   = PH_AAD;
                    state_next   = S_GLOAD;
                end
                else
                begin
                    state_next = S_DO;
                end
            end
            S_GLOAD:
            begin
                cmd.gen_load = 1'b1;
                gen_cnt_next = '0;
                state_next   = S_GEN;
            end
            S_GEN:
            begin
                cmd.gen_step = 1'b1;
                gen_cnt_next = gen_cnt_reg + 1'b1;
                if (gen_cnt_reg == GEN_CNT_W'(GEN_STEPS - 1))
                begin
                    state_next = S_GEND;
                end
            end
            S_GEND:
            begin
                cmd.gen_done = 1'b1;
                if (blk0_reg)
                begin
                    blk0_next  = 1'b0;
                    state_next = S_GLOAD;
                end
                else
                begin
                    state_next = gen_ret_reg;
                end
            end
            S_DO:
            begin
                unique case (kind_reg)
                    IK_AAD:
                    begin
                        cmd.mac_aad = 1'b1;
                        if (stat.fill_15)
                        begin
                            cmd.mul_start = 1'b1;
                            mul_ret_next  = S_IDLE;
                            state_next    = S_MUL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    IK_TEXT:
                    begin
                        phase_next = PH_TEXT;
                        if ((phase_reg == PH_AAD) && !stat.fill_zero)
                        begin
                            cmd.mul_start = 1'b1;
                            mul_ret_next  = S_TEXT;
                            state_next    = S_MUL;
                        end
                        else
                        begin
                            state_next = S_TEXT;
                        end
                    end
                    IK_TAG:
                    begin
                        phase_next = PH_TAG;
                        if ((phase_reg != PH_TAG) && !stat.fill_zero)
                        begin
                            cmd.mul_start = 1'b1;
                            mul_ret_next  = S_DO;
                            state_next    = S_MUL;
                        end
                        else
                        begin
                            cmd.tag_store = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    IK_FIN:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_MUL;
                        if (!stat.fill_zero)
                        begin
                            mul_ret_next = S_DO;
                        end
                        else
                        begin
                            cmd.mul_len  = 1'b1;
                            mul_ret_next = S_FIN1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TEXT:
            begin
                cmd.text_step = 1'b1;
                ek_next       = EM_TEXT;
                if (stat.fill_15)
                begin
                    cmd.mul_start = 1'b1;
                    mul_ret_next  = S_TEXT2;
                    state_next    = S_MUL;
                end
                else
                begin
                    state_next = S_TEXT2;
                end
            end
            S_TEXT2:
            begin
                if (stat.pos_zero)
                begin
                    gen_ret_next = S_EMIT;
                    state_next   = S_GLOAD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_last = (mul_cnt_reg == 4'd15);
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == 4'd15)
                begin
                    state_next = mul_ret_reg;
                end
            end
            S_FIN1:
            begin
                cmd.fin_fold = 1'b1;
                state_next   = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.fin_sub = 1'b1;
                state_next  = S_FIN3;
            end
            S_FIN3:
            begin
                cmd.fin_pad = 1'b1;
                phase_next  = PH_IDLE;
                ek_next     = direction ? EM_STAT : EM_TAG;
                idx_next    = '0;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_last = (ek_reg != EM_TAG) || (idx_reg == 4'd15);
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if ((ek_reg == EM_TAG) && (idx_reg != 4'd15))
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.mul_start)
        begin
            mul_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gen_ret_reg <= S_IDLE;
            mul_ret_reg <= S_IDLE;
            phase_reg   <= PH_IDLE;
            kind_reg    <= IK_AAD;
            ek_reg      <= EM_TEXT;
            gen_cnt_reg <= '0;
            mul_cnt_reg <= '0;
            idx_reg     <= '0;
            blk0_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gen_ret_reg <= gen_ret_next;
            mul_ret_reg <= mul_ret_next;
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            ek_reg      <= ek_next;
            gen_cnt_reg <= gen_cnt_next;
            mul_cnt_reg <= mul_cnt_next;
            idx_reg     <= idx_next;
            blk0_reg    <= blk0_next;
        end
    end

    `CPA_ASSERT_NEXT(a_accept_check, s_tvalid && s_tready, state_reg == S_CHECK, "accepted word not checked")
    `CPA_ASSERT_NEXT(a_mul_enter, cmd.mul_start, state_reg == S_MUL, "multiply did not start")
    `CPA_ASSERT_IMP(a_tag_phase, (state_reg == S_EMIT) && (ek_reg == EM_TAG), phase_reg == PH_IDLE, "tag out while message open")

endmodule

// ===== design/cpa_dp.sv =====
`include "chacha20_poly1305_aead_macros.svh"

module cpa_dp
    import cpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cpa_cfg_t    cfg,
    input  cpa_cmd_t    cmd,
    input  logic [7:0]  s_tdata,
    input  logic        m_tready,
    output cpa_stat_t   stat,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [15:0][31:0] x_reg;
    logic [15:0][31:0] ks_reg;
    logic [15:0][31:0] init_w;
    logic [15:0][31:0] sum_w;
    logic [15:0][31:0] x_col;
    logic [15:0][31:0] x_dia;
    logic [31:0]       ctr_reg;
    logic [5:0]        pos_reg;
    logic [127:0]      r_reg;
    logic [127:0]      pad_reg;
    logic [130:0]      h_reg;
    logic [131:0]      mh_reg;
    logic [130:0]      acc_reg;
    logic [127:0]      buf_reg;
    logic [4:0]        fill_reg;
    logic [63:0]       aad_cnt_reg;
    logic [63:0]       text_cnt_reg;
    logic [127:0]      rtag_reg;
    logic [4:0]        tcnt_reg;
    logic [129:0]      tag_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        o_reg;
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic [1:0]        m_kind_reg;
    logic              m_auth_reg;
    logic              m_last_reg;

    logic [31:0]  ks_word;
    logic [7:0]   ks_byte;
    logic [7:0]   o_byte;
    logic [7:0]   digit;
    logic [139:0] prod;
    logic [140:0] mul_sum;
    logic [13:0]  hi5;
    logic [130:0] mul_red;
    logic [127:0] buf_w;
    logic [127:0] blk;
    logic [130:0] fold1;
    logic [129:0] fold2;
    logic [7:0]   e_byte;
    logic         e_auth;

    always_comb
    begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        init_w[4]  = cfg.key_word0[31:0];
        init_w[5]  = cfg.key_word0[63:32];
        init_w[6]  = cfg.key_word1[31:0];
        init_w[7]  = cfg.key_word1[63:32];
        init_w[8]  = cfg.key_word2[31:0];
        init_w[9]  = cfg.key_word2[63:32];
        init_w[10] = cfg.key_word3[31:0];
        init_w[11] = cfg.key_word3[63:32];
        init_w[12] = ctr_reg;
        init_w[13] = cfg.nonce_low[31:0];
        init_w[14] = cfg.nonce_low[63:32];
        init_w[15] = cfg.nonce_high;
        for (int i = 0; i < 16; i++)
        begin
            sum_w[i] = x_reg[i] + init_w[i];
        end
    end

    always_comb
    begin
        x_col = x_reg;
        x_dia = x_reg;
        for (int i = 0; i < 4; i++)
        begin
            {x_col[i], x_col[4 + i], x_col[8 + i], x_col[12 + i]} =
                qhalf(x_reg[i], x_reg[4 + i], x_reg[8 + i], x_reg[12 + i], cmd.gen_half);
            {x_dia[i], x_dia[4 + ((i + 1) & 3)], x_dia[8 + ((i + 2) & 3)],
             x_dia[12 + ((i + 3) & 3)]} =
                qhalf(x_reg[i], x_reg[4 + ((i + 1) & 3)], x_reg[8 + ((i + 2) & 3)],
                      x_reg[12 + ((i + 3) & 3)], cmd.gen_half);
        end
    end

    always_comb
    begin
        ks_word = ks_reg[pos_reg[5:2]];
        ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];
        o_byte  = byte_reg ^ ks_byte;
        digit   = r_reg[{~cmd.mul_digit, 3'b000} +: 8];
        prod    = mh_reg * digit;
        mul_sum = {2'b00, acc_reg, 8'h00} + {1'b0, prod};
        hi5     = {1'b0, mul_sum[140:130], 2'b00} + {3'b000, mul_sum[140:130]};
        mul_red = {1'b0, mul_sum[129:0]} + {117'd0, hi5};
        buf_w   = buf_reg;
        if (cmd.mac_aad)
        begin
            buf_w[{fill_reg[3:0], 3'b000} +: 8] = byte_reg;
        end
        else if (cmd.text_step)
        begin
            buf_w[{fill_reg[3:0], 3'b000} +: 8] = cfg.direction ? byte_reg : o_byte;
        end
        blk     = cmd.mul_len ? {text_cnt_reg, aad_cnt_reg} : buf_w;
        fold1   = {1'b0, h_reg[129:0]} + (h_reg[130] ? 131'd5 : 131'd0);
        fold2   = fold1[129:0] + (fold1[130] ? 130'd5 : 130'd0);
    end

    always_comb
    begin
        e_byte = 8'h00;
        e_auth = 1'b0;
        unique case (cmd.emit_kind)
            EM_TEXT: e_byte = o_reg;
            EM_TAG:  e_byte = tag_reg[{cmd.emit_idx, 3'b000} +: 8];
            EM_STAT: e_auth = (tag_reg[127:0] == rtag_reg) && (tcnt_reg == 5'd16);
            EM_REJ:  e_byte = 8'h00;
            default: e_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg      <= '0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            aad_cnt_reg  <= '0;
            text_cnt_reg <= '0;
            tcnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                ctr_reg      <= '0;
                pos_reg      <= '0;
                aad_cnt_reg  <= '0;
                text_cnt_reg <= '0;
                tcnt_reg     <= '0;
            end
            if (cmd.gen_done && cmd.gen_blk0)
            begin
                ctr_reg <= ctr_reg + 1'b1;
            end
            if (cmd.mac_aad)
            begin
                aad_cnt_reg <= aad_cnt_reg + 1'b1;
            end
            if (cmd.text_step)
            begin
                text_cnt_reg <= text_cnt_reg + 1'b1;
                pos_reg      <= pos_reg + 1'b1;
                if (pos_reg == 6'd63)
                begin
                    ctr_reg <= ctr_reg + 1'b1;
                end
            end
            if (cmd.tag_store)
            begin
                tcnt_reg <= tcnt_reg + 1'b1;
            end
            if (cmd.start || (cmd.mul_start && !cmd.mul_len))
            begin
                fill_reg <= '0;
            end
            else if (cmd.mac_aad || cmd.text_step)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= s_tdata;
        end
        if (cmd.gen_load)
        begin
            x_reg <= init_w;
        end
        else if (cmd.gen_step)
        begin
            x_reg <= cmd.gen_diag ? x_dia : x_col;
        end
        if (cmd.gen_done)
        begin
            if (cmd.gen_blk0)
            begin
                r_reg   <= {sum_w[3], sum_w[2], sum_w[1], sum_w[0]} & R_CLAMP;
                pad_reg <= {sum_w[7], sum_w[6], sum_w[5], sum_w[4]};
            end
            else
            begin
                ks_reg <= sum_w;
            end
        end
        if (cmd.start || (cmd.mul_start && !cmd.mul_len))
        begin
            buf_reg <= '0;
        end
        else if (cmd.mac_aad || cmd.text_step)
        begin
            buf_reg <= buf_w;
        end
        if (cmd.text_step)
        begin
            o_reg <= o_byte;
        end
        if (cmd.tag_store)
        begin
            rtag_reg[{tcnt_reg[3:0], 3'b000} +: 8] <= byte_reg;
        end
        if (cmd.start)
        begin
            h_reg <= '0;
        end
        else if (cmd.mul_step && cmd.mul_last)
        begin
            h_reg <= mul_red;
        end
        if (cmd.mul_start)
        begin
            mh_reg  <= {1'b0, h_reg} + {4'b0001, blk};
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= mul_red;
        end
        if (cmd.fin_fold)
        begin
            tag_reg <= fold2;
        end
        else if (cmd.fin_sub)
        begin
            if (tag_reg >= POLY_P)
            begin
                tag_reg <= tag_reg - POLY_P;
            end
        end
        else if (cmd.fin_pad)
        begin
            tag_reg <= {2'b00, tag_reg[127:0] + pad_reg};
        end
        if (cmd.emit)
        begin
            m_byte_reg <= e_byte;
            m_kind_reg <= cmd.emit_kind;
            m_auth_reg <= e_auth;
            m_last_reg <= cmd.emit_last;
        end
    end

    assign stat.fill_zero = (fill_reg == 5'd0);
    assign stat.fill_15   = (fill_reg == 5'd15);
    assign stat.pos_zero  = (pos_reg == 6'd0);
    assign stat.tcnt_full = (tcnt_reg == 5'd16);
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_auth_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `CPA_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= 5'd16, "block buffer overfilled")
    `CPA_ASSERT_IMP(a_tag_room, cmd.tag_store, tcnt_reg < 5'd16, "tag byte beyond sixteen")
    `CPA_ASSERT_IMP(a_emit_free, cmd.emit, !m_valid_reg || m_tready, "result overwritten")

endmodule

// ===== design/chacha20_poly1305_aead.sv =====
// ChaCha20-Poly1305 AEAD engine, one byte per input word.
// Input stream: s_tuser gives the item kind (aad byte, text byte, received tag byte,
// finish) and s_tdata the byte. Output stream: m_tdata carries the byte and the
// authentication flag, m_tuser the result kind and m_tlast the final result of an item.
// Key, nonce and direction are written over the APB port while the engine is idle;
// the user must keep to this, as the block does not enforce it. One item is in work at a
// time. An aad byte is absorbed, a tag byte stored and a text byte also combined with the
// keystream and sent out; the byte-serial Poly1305 multiplier runs each time 16 bytes are
// absorbed, and the ChaCha round unit makes a new block each time 64 text bytes are used.
// The first item of a message adds two ChaCha blocks. Finish results follow one per cycle unless stalled.
// Reset returns the engine to idle with no message open and the configuration cleared.
// When the receiver stalls, a finished result waits in the output register and the
// engine stops only when it must hand over the next result.
module chacha20_poly1305_aead
    import cpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // item_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte, auth_ok, zero fill
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cpa_cfg_t  cfg_reg;
    cpa_cmd_t  cmd;
    cpa_stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                REG_KEY0:   cfg_reg.key_word0  <= pwdata;
                REG_KEY1:   cfg_reg.key_word1  <= pwdata;
                REG_KEY2:   cfg_reg.key_word2  <= pwdata;
                REG_KEY3:   cfg_reg.key_word3  <= pwdata;
                REG_NONCEL: cfg_reg.nonce_low  <= pwdata;
                REG_NONCEH: cfg_reg.nonce_high <= pwdata[31:0];
                REG_DIR:    cfg_reg.direction  <= pwdata[0];
                default:    cfg_reg.direction  <= cfg_reg.direction;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_KEY0:   prdata = cfg_reg.key_word0;
            REG_KEY1:   prdata = cfg_reg.key_word1;
            REG_KEY2:   prdata = cfg_reg.key_word2;
            REG_KEY3:   prdata = cfg_reg.key_word3;
            REG_NONCEL: prdata = cfg_reg.nonce_low;
            REG_NONCEH: prdata = {32'd0, cfg_reg.nonce_high};
            REG_DIR:    prdata = {63'd0, cfg_reg.direction};
            default:    prdata = 64'd0;
        endcase
    end

    cpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .direction (cfg_reg.direction),
        .stat      (stat),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    cpa_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
